### hw/rtl/pvt_pkg.sv
`timescale 1ns / 1ps

package pvt_pkg;

    // sizes fixed by the register map and field formats
    localparam int CoordWidthDefault = 24;
    localparam int MinVertices       = 3;
    localparam int CoefWidth         = 32;
    localparam int TrigWidth         = 18;
    localparam int ModeWidth         = 3;
    localparam int CountWidth        = 2;
    localparam int CfgIndexWidth     = 3;
    localparam int CfgDataWidth      = 32;

    // binary point moves: Q.16 to Q.8 and Q.24 to Q.8
    localparam int FracShiftNarrow   = 8;
    localparam int FracShiftWide     = 16;

    typedef enum logic [ModeWidth-1:0] {
        MODE_SCALE   = 3'd0,
        MODE_ROTATE  = 3'd1,
        MODE_SHEAR_X = 3'd2,
        MODE_SHEAR_Y = 3'd3,
        MODE_MOVE    = 3'd4
    } t_mode;

    typedef enum logic [CfgIndexWidth-1:0] {
        CFG_MODE    = 3'd0,
        CFG_COEF_X  = 3'd1,
        CFG_COEF_Y  = 3'd2,
        CFG_ROT_COS = 3'd3,
        CFG_ROT_SIN = 3'd4,
        CFG_PIVOT_X = 3'd5,
        CFG_PIVOT_Y = 3'd6
    } t_cfg_index;

    // how the two products of one coordinate are combined
    typedef struct packed {
        logic sub;        // a - b instead of a + b
        logic wide_shift; // drop 16 fraction bits instead of 8
        logic negate;     // subtract the rounded term from the base
    } t_term_ctl;

endpackage

### hw/rtl/polygon_vertex_transform.sv
`timescale 1ns / 1ps
// the result passes the input, product and result registers, in that order
// throughput: one vertex per cycle; each stage moves on when the next one is empty or moving
// the four multipliers of the product stage set the clock, one multiply deep
// reset (synchronous, active low): pipeline empty, vertex count zero, registers to defaults
// configuration writes are taken every cycle and go straight to the register file

module polygon_vertex_transform #(
    parameter int COORD_WIDTH = pvt_pkg::CoordWidthDefault
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // configuration write channel
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [pvt_pkg::CfgIndexWidth-1:0]   i_cfg_index,
    input  logic [pvt_pkg::CfgDataWidth-1:0]    i_cfg_data,
    // vertex input
    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic signed [COORD_WIDTH-1:0]       i_vertex_x,
    input  logic signed [COORD_WIDTH-1:0]       i_vertex_y,
    input  logic                                i_last_vertex,
    // result output
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic signed [COORD_WIDTH-1:0]       o_result_x,
    output logic signed [COORD_WIDTH-1:0]       o_result_y,
    output logic                                o_end_of_polygon,
    output logic                                o_too_few_points,
    output logic [COORD_WIDTH-1:0]              o_box_width,
    output logic [COORD_WIDTH-1:0]              o_box_height
);
    import pvt_pkg::*;

    localparam int LW = COORD_WIDTH + 1;
    localparam int RW = CoefWidth;
    localparam int PW = COORD_WIDTH + CoefWidth;
    localparam logic [CountWidth-1:0] CountMax = CountWidth'(MinVertices);

    // configuration registers
    t_mode                        r_mode;
    logic signed [CoefWidth-1:0]  r_coef_x;
    logic signed [CoefWidth-1:0]  r_coef_y;
    logic signed [TrigWidth-1:0]  r_rot_cos;
    logic signed [TrigWidth-1:0]  r_rot_sin;
    logic signed [COORD_WIDTH-1:0] r_pivot_x;
    logic signed [COORD_WIDTH-1:0] r_pivot_y;

    // pipeline handshake
    logic w_s1_ready;
    logic w_s2_ready;
    logic w_s0_load;
    logic w_s1_load;
    logic w_s2_load;

    // input stage
    logic                          r_s0_valid;
    logic signed [COORD_WIDTH-1:0] r_s0_x;
    logic signed [COORD_WIDTH-1:0] r_s0_y;
    logic                          r_s0_last;

    // bounding box tracking
    logic [CountWidth-1:0]         r_count;
    logic signed [COORD_WIDTH-1:0] r_min_x;
    logic signed [COORD_WIDTH-1:0] r_max_x;
    logic signed [COORD_WIDTH-1:0] r_min_y;
    logic signed [COORD_WIDTH-1:0] r_max_y;
    logic [CountWidth-1:0]         n_count;
    logic signed [COORD_WIDTH-1:0] n_min_x;
    logic signed [COORD_WIDTH-1:0] n_max_x;
    logic signed [COORD_WIDTH-1:0] n_min_y;
    logic signed [COORD_WIDTH-1:0] n_max_y;

    // product stage operands
    logic          n_trunc_x_corr;
    logic          n_trunc_y_corr;
    logic signed [LW-1:0] n_trunc_x;
    logic signed [LW-1:0] n_trunc_y;
    logic signed [LW-1:0] n_ext_x;
    logic signed [LW-1:0] n_ext_y;
    logic signed [LW-1:0] n_dx;
    logic signed [LW-1:0] n_dy;
    logic signed [LW-1:0] n_la_x;
    logic signed [LW-1:0] n_lb_x;
    logic signed [LW-1:0] n_la_y;
    logic signed [LW-1:0] n_lb_y;
    logic signed [RW-1:0] n_ra_x;
    logic signed [RW-1:0] n_rb_x;
    logic signed [RW-1:0] n_ra_y;
    logic signed [RW-1:0] n_rb_y;
    logic signed [LW-1:0] n_base_x;
    logic signed [LW-1:0] n_base_y;
    t_term_ctl            n_ctl_x;
    t_term_ctl            n_ctl_y;

    // product stage registers
    logic                 r_s1_valid;
    logic signed [PW-1:0] r_s1_a_x;
    logic signed [PW-1:0] r_s1_b_x;
    logic signed [PW-1:0] r_s1_a_y;
    logic signed [PW-1:0] r_s1_b_y;
    logic signed [LW-1:0] r_s1_base_x;
    logic signed [LW-1:0] r_s1_base_y;
    t_term_ctl            r_s1_ctl_x;
    t_term_ctl            r_s1_ctl_y;
    logic                 r_s1_last;
    logic                 r_s1_few;
    logic [COORD_WIDTH-1:0] r_s1_box_w;
    logic [COORD_WIDTH-1:0] r_s1_box_h;

    // result stage
    logic signed [COORD_WIDTH-1:0] n_res_x;
    logic signed [COORD_WIDTH-1:0] n_res_y;
    logic                          r_s2_valid;
    logic signed [COORD_WIDTH-1:0] r_s2_x;
    logic signed [COORD_WIDTH-1:0] r_s2_y;
    logic                          r_s2_last;
    logic                          r_s2_few;
    logic [COORD_WIDTH-1:0]        r_s2_box_w;
    logic [COORD_WIDTH-1:0]        r_s2_box_h;

    // configuration register file
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode    <= MODE_SCALE;
            r_coef_x  <= 32'sd65536;
            r_coef_y  <= 32'sd65536;
            r_rot_cos <= 18'sd65536;
            r_rot_sin <= '0;
            r_pivot_x <= '0;
            r_pivot_y <= '0;
        end else if (i_cfg_valid) begin
            case (t_cfg_index'(i_cfg_index))
                CFG_MODE:    r_mode    <= t_mode'(i_cfg_data[ModeWidth-1:0]);
                CFG_COEF_X:  r_coef_x  <= i_cfg_data[CoefWidth-1:0];
                CFG_COEF_Y:  r_coef_y  <= i_cfg_data[CoefWidth-1:0];
                CFG_ROT_COS: r_rot_cos <= i_cfg_data[TrigWidth-1:0];
                CFG_ROT_SIN: r_rot_sin <= i_cfg_data[TrigWidth-1:0];
                CFG_PIVOT_X: r_pivot_x <= i_cfg_data[COORD_WIDTH-1:0];
                CFG_PIVOT_Y: r_pivot_y <= i_cfg_data[COORD_WIDTH-1:0];
                default: ;
            endcase
        end
    end

    // stage moves when the next stage is empty or moving on
    assign w_s2_ready = !r_s2_valid || i_ready;
    assign w_s1_ready = !r_s1_valid || w_s2_ready;
    assign o_ready    = !r_s0_valid || w_s1_ready;
    assign w_s0_load  = i_valid && o_ready;
    assign w_s1_load  = r_s0_valid && w_s1_ready;
    assign w_s2_load  = r_s1_valid && w_s2_ready;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_valid <= 1'b0;
        end else if (o_ready) begin
            r_s0_valid <= i_valid;
        end
        if (w_s0_load) begin
            r_s0_x    <= i_vertex_x;
            r_s0_y    <= i_vertex_y;
            r_s0_last <= i_last_vertex;
        end
    end

    // bounding box and vertex count, first vertex of a polygon overwrites
    always_comb begin
        if (r_count == '0) begin
            n_min_x = r_s0_x;
            n_max_x = r_s0_x;
            n_min_y = r_s0_y;
            n_max_y = r_s0_y;
        end else begin
            n_min_x = (r_s0_x < r_min_x) ? r_s0_x : r_min_x;
            n_max_x = (r_s0_x > r_max_x) ? r_s0_x : r_max_x;
            n_min_y = (r_s0_y < r_min_y) ? r_s0_y : r_min_y;
            n_max_y = (r_s0_y > r_max_y) ? r_s0_y : r_max_y;
        end
        n_count = (r_count == CountMax) ? r_count : r_count + 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (w_s1_load) begin
            r_count <= r_s0_last ? '0 : n_count;
        end
        if (w_s1_load) begin
            r_min_x <= n_min_x;
            r_max_x <= n_max_x;
            r_min_y <= n_min_y;
            r_max_y <= n_max_y;
        end
    end

    // integer part toward zero, pivot offsets with screen y pointing down
    always_comb begin
        n_trunc_x_corr = r_s0_x[COORD_WIDTH-1] && (r_s0_x[FracShiftNarrow-1:0] != '0);
        n_trunc_y_corr = r_s0_y[COORD_WIDTH-1] && (r_s0_y[FracShiftNarrow-1:0] != '0);
        n_trunc_x = LW'(r_s0_x >>> FracShiftNarrow) + LW'(n_trunc_x_corr);
        n_trunc_y = LW'(r_s0_y >>> FracShiftNarrow) + LW'(n_trunc_y_corr);
        n_ext_x   = LW'(r_s0_x);
        n_ext_y   = LW'(r_s0_y);
        n_dx      = n_ext_x - LW'(r_pivot_x);
        n_dy      = LW'(r_pivot_y) - n_ext_y;
    end

    // operand selection per mode
    always_comb begin
        n_la_x   = '0;
        n_ra_x   = '0;
        n_lb_x   = '0;
        n_rb_x   = '0;
        n_la_y   = '0;
        n_ra_y   = '0;
        n_lb_y   = '0;
        n_rb_y   = '0;
        n_base_x = n_ext_x;
        n_base_y = n_ext_y;
        n_ctl_x  = '0;
        n_ctl_y  = '0;
        case (r_mode)
            MODE_SCALE: begin
                n_la_x   = n_trunc_x;
                n_ra_x   = r_coef_x;
                n_la_y   = n_trunc_y;
                n_ra_y   = r_coef_y;
                n_base_x = '0;
                n_base_y = '0;
            end
            MODE_ROTATE: begin
                n_la_x   = n_dx;
                n_ra_x   = RW'(r_rot_cos);
                n_lb_x   = n_dy;
                n_rb_x   = RW'(r_rot_sin);
                n_la_y   = n_dx;
                n_ra_y   = RW'(r_rot_sin);
                n_lb_y   = n_dy;
                n_rb_y   = RW'(r_rot_cos);
                n_base_x = LW'(r_pivot_x);
                n_base_y = LW'(r_pivot_y);
                n_ctl_x  = '{sub: 1'b1, wide_shift: 1'b1, negate: 1'b0};
                n_ctl_y  = '{sub: 1'b0, wide_shift: 1'b1, negate: 1'b1};
            end
            MODE_SHEAR_X: begin
                n_la_x  = n_ext_y;
                n_ra_x  = r_coef_x;
                n_ctl_x = '{sub: 1'b0, wide_shift: 1'b1, negate: 1'b0};
            end
            MODE_SHEAR_Y: begin
                n_la_y  = n_ext_x;
                n_ra_y  = r_coef_x;
                n_ctl_y = '{sub: 1'b0, wide_shift: 1'b1, negate: 1'b0};
            end
            MODE_MOVE: begin
                n_la_x = LW'(1);
                n_ra_x = r_coef_x;
                n_la_y = LW'(1);
                n_ra_y = r_coef_y;
            end
            default: ;
        endcase
    end

    // product register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (w_s1_ready) begin
            r_s1_valid <= r_s0_valid;
        end
        if (w_s1_load) begin
            r_s1_a_x    <= PW'(n_la_x) * PW'(n_ra_x);
            r_s1_b_x    <= PW'(n_lb_x) * PW'(n_rb_x);
            r_s1_a_y    <= PW'(n_la_y) * PW'(n_ra_y);
            r_s1_b_y    <= PW'(n_lb_y) * PW'(n_rb_y);
            r_s1_base_x <= n_base_x;
            r_s1_base_y <= n_base_y;
            r_s1_ctl_x  <= n_ctl_x;
            r_s1_ctl_y  <= n_ctl_y;
            r_s1_last   <= r_s0_last;
            if (r_s0_last) begin
                r_s1_few   <= (int'(n_count) < MinVertices);
                r_s1_box_w <= n_max_x - n_min_x;
                r_s1_box_h <= n_max_y - n_min_y;
            end else begin
                r_s1_few   <= 1'b0;
                r_s1_box_w <= '0;
                r_s1_box_h <= '0;
            end
        end
    end

    // rounding, base add and saturation per coordinate
    pvt_finish #(
        .COORD_WIDTH(COORD_WIDTH)
    ) u_finish_x (
        .i_prod_a (r_s1_a_x),
        .i_prod_b (r_s1_b_x),
        .i_ctl    (r_s1_ctl_x),
        .i_base   (r_s1_base_x),
        .o_result (n_res_x)
    );

    pvt_finish #(
        .COORD_WIDTH(COORD_WIDTH)
    ) u_finish_y (
        .i_prod_a (r_s1_a_y),
        .i_prod_b (r_s1_b_y),
        .i_ctl    (r_s1_ctl_y),
        .i_base   (r_s1_base_y),
        .o_result (n_res_y)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else if (w_s2_ready) begin
            r_s2_valid <= r_s1_valid;
        end
        if (w_s2_load) begin
            r_s2_x     <= n_res_x;
            r_s2_y     <= n_res_y;
            r_s2_last  <= r_s1_last;
            r_s2_few   <= r_s1_few;
            r_s2_box_w <= r_s1_box_w;
            r_s2_box_h <= r_s1_box_h;
        end
    end

    assign o_valid          = r_s2_valid;
    assign o_result_x       = r_s2_x;
    assign o_result_y       = r_s2_y;
    assign o_end_of_polygon = r_s2_last;
    assign o_too_few_points = r_s2_few;
    assign o_box_width      = r_s2_box_w;
    assign o_box_height     = r_s2_box_h;

endmodule

### hw/rtl/pvt_finish.sv
`timescale 1ns / 1ps

module pvt_finish #(
    parameter int COORD_WIDTH = pvt_pkg::CoordWidthDefault
) (
    input  logic signed [COORD_WIDTH+31:0] i_prod_a,
    input  logic signed [COORD_WIDTH+31:0] i_prod_b,
    input  pvt_pkg::t_term_ctl             i_ctl,
    input  logic signed [COORD_WIDTH:0]    i_base,
    output logic signed [COORD_WIDTH-1:0]  o_result
);
    import pvt_pkg::*;

    localparam int PW = COORD_WIDTH + CoefWidth;
    localparam int SW = PW + 3;

    logic signed [SW-1:0] w_half;
    logic signed [SW-1:0] w_sum;
    logic signed [SW-1:0] w_shifted;
    logic signed [SW-1:0] w_term;
    logic signed [SW-1:0] w_total;
    logic                 w_in_range;

    // combine products and add half an output lsb
    always_comb begin
        if (i_ctl.wide_shift) begin
            w_half = SW'(1) <<< (FracShiftWide - 1);
        end else begin
            w_half = SW'(1) <<< (FracShiftNarrow - 1);
        end
        if (i_ctl.sub) begin
            w_sum = SW'(i_prod_a) - SW'(i_prod_b) + w_half;
        end else begin
            w_sum = SW'(i_prod_a) + SW'(i_prod_b) + w_half;
        end
    end

    // floor to the output binary point, then apply to the base
    always_comb begin
        if (i_ctl.wide_shift) begin
            w_shifted = w_sum >>> FracShiftWide;
        end else begin
            w_shifted = w_sum >>> FracShiftNarrow;
        end
        if (i_ctl.negate) begin
            w_term = -w_shifted;
        end else begin
            w_term = w_shifted;
        end
        w_total = w_term + SW'(i_base);
    end

    // saturate to the coordinate range
    assign w_in_range = (&w_total[SW-1:COORD_WIDTH-1]) | (~|w_total[SW-1:COORD_WIDTH-1]);

    always_comb begin
        if (w_in_range) begin
            o_result = w_total[COORD_WIDTH-1:0];
        end else if (w_total[SW-1]) begin
            o_result = {1'b1, {(COORD_WIDTH-1){1'b0}}};
        end else begin
            o_result = {1'b0, {(COORD_WIDTH-1){1'b1}}};
        end
    end

endmodule
